>>> src/svc_pkg.sv
// ----------------------------------------------------------------------------
// svc_pkg: save header CRC validator shared definitions
// Widths, header layout, CRC constants and register indexes.
// ----------------------------------------------------------------------------
package svc_pkg;

    localparam int unsigned HEADER_BYTES = 64;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_VERSION = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLAG    = 2'd1;

    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;

    // magic bytes, byte 0 in the low lane
    localparam logic [63:0] MAGIC = 64'h3156_5331_4D44_5346;

    localparam logic [31:0] VERSION_OFS = 32'd8;
    localparam logic [31:0] SIZE_OFS    = 32'd12;
    localparam logic [31:0] CHECK_OFS   = 32'd16;
    localparam logic [31:0] CHECK_END   = 32'd20;
    localparam logic [31:0] FLAG_OFS    = 32'd39;
    localparam logic [31:0] BODY_OFS    = 32'(HEADER_BYTES);

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef logic [7:0]  byte_t;
    typedef logic [31:0] word_t;

endpackage

>>> src/svc_ifs.sv
// ----------------------------------------------------------------------------
// svc_in_if / svc_out_if: validator stream channels
// Valid/ready channels for the byte stream and the per-stream verdict.
// ----------------------------------------------------------------------------
interface svc_in_if;
    logic          valid;
    logic          ready;
    svc_pkg::byte_t data_byte;
    logic          last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface svc_out_if;
    logic          valid;
    logic          ready;
    logic          accepted;
    svc_pkg::word_t stream_len;
    svc_pkg::word_t stream_crc;

    modport source (output valid, output accepted, output stream_len,
                    output stream_crc, input ready);
    modport sink   (input valid, input accepted, input stream_len,
                    input stream_crc, output ready);
endinterface

>>> src/svc_crc_byte.sv
// ----------------------------------------------------------------------------
// svc_crc_byte: reflected CRC-32 byte update
// Advances a CRC register by one byte, least significant bit first.
// ----------------------------------------------------------------------------
module svc_crc_byte (
    input  svc_pkg::word_t crc_in,
    input  svc_pkg::byte_t data,
    output svc_pkg::word_t crc_out
);

    always_comb
    begin
        svc_pkg::word_t acc;
        acc = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            acc = acc[0] ? ((acc >> 1) ^ svc_pkg::CRC_POLY) : (acc >> 1);
        end
        crc_out = acc;
    end

endmodule

>>> src/save_header_crc_validator.sv
// ----------------------------------------------------------------------------
// save_header_crc_validator: save stream header and CRC check
// Checks magic, version, size, flag and body CRC of a byte stream and
// reports a verdict, the byte count and the whole-stream CRC.
//
//   channel   dir   handshake     word
//   stream    in    valid/ready   data_byte, last_byte
//   verdict   out   valid/ready   accepted, stream_len, stream_crc
//   config    in    cfg_we        cfg_index, cfg_data
//
// One byte per cycle while the stream is ready; both CRC byte updates and
// field capture finish in the cycle a byte is taken. The verdict appears
// in the output register in the cycle after the last byte is taken. Stream
// is ready while that register is empty or being drained. Reset clears
// stream state and sets both config registers to 1.
// ----------------------------------------------------------------------------
module save_header_crc_validator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [svc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [svc_pkg::CFG_DATA_W-1:0]       cfg_data,
    svc_in_if.sink                               stream,
    svc_out_if.source                            verdict
);

    svc_pkg::word_t version_cfg_reg;
    svc_pkg::byte_t flag_cfg_reg;

    svc_pkg::word_t position_reg, position_next;
    logic           magic_reg, magic_next;
    svc_pkg::word_t version_reg, version_next;
    svc_pkg::word_t size_reg, size_next;
    svc_pkg::word_t check_reg, check_next;
    logic           flag_reg, flag_next;
    svc_pkg::word_t body_crc_reg, body_crc_next;
    svc_pkg::word_t whole_crc_reg, whole_crc_next;
    logic           ovf_reg, ovf_next;

    logic           out_valid_reg;
    logic           out_accepted_reg;
    svc_pkg::word_t out_count_reg;
    svc_pkg::word_t out_crc_reg;

    svc_pkg::word_t body_crc_upd;
    logic           take;
    logic           saturated;
    logic           ok;

    svc_crc_byte u_whole_crc (
        .crc_in  (whole_crc_reg),
        .data    (stream.data_byte),
        .crc_out (whole_crc_next)
    );

    svc_crc_byte u_body_crc (
        .crc_in  (body_crc_reg),
        .data    (stream.data_byte),
        .crc_out (body_crc_upd)
    );

    assign stream.ready = !out_valid_reg || verdict.ready;
    assign take         = stream.valid && stream.ready;
    assign saturated    = (position_reg == svc_pkg::COUNT_MAX);

    always_comb
    begin
        position_next = position_reg;
        magic_next    = magic_reg;
        version_next  = version_reg;
        size_next     = size_reg;
        check_next    = check_reg;
        flag_next     = flag_reg;
        ovf_next      = ovf_reg || saturated;
        body_crc_next = (position_reg >= svc_pkg::BODY_OFS) ? body_crc_upd : body_crc_reg;
        if (!saturated)
        begin
            position_next = position_reg + 32'd1;
            if (position_reg < svc_pkg::VERSION_OFS)
            begin
                if (stream.data_byte != svc_pkg::MAGIC[{position_reg[2:0], 3'b000} +: 8])
                begin
                    magic_next = 1'b0;
                end
            end
            else if (position_reg < svc_pkg::SIZE_OFS)
            begin
                version_next[{position_reg[1:0], 3'b000} +: 8] = stream.data_byte;
            end
            else if (position_reg < svc_pkg::CHECK_OFS)
            begin
                size_next[{position_reg[1:0], 3'b000} +: 8] = stream.data_byte;
            end
            else if (position_reg < svc_pkg::CHECK_END)
            begin
                check_next[{position_reg[1:0], 3'b000} +: 8] = stream.data_byte;
            end
            else if (position_reg == svc_pkg::FLAG_OFS)
            begin
                flag_next = (stream.data_byte == flag_cfg_reg);
            end
        end
    end

    assign ok = !ovf_next
        && (position_next >= svc_pkg::BODY_OFS)
        && magic_next
        && (version_next == version_cfg_reg)
        && (size_next == position_next)
        && flag_next
        && ((body_crc_next ^ svc_pkg::CRC_PRESET) == check_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_cfg_reg <= 32'd1;
            flag_cfg_reg    <= 8'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                svc_pkg::CFG_VERSION: version_cfg_reg <= cfg_data;
                svc_pkg::CFG_FLAG:    flag_cfg_reg    <= cfg_data[7:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg  <= '0;
            magic_reg     <= 1'b1;
            version_reg   <= '0;
            size_reg      <= '0;
            check_reg     <= '0;
            flag_reg      <= 1'b0;
            body_crc_reg  <= svc_pkg::CRC_PRESET;
            whole_crc_reg <= svc_pkg::CRC_PRESET;
            ovf_reg       <= 1'b0;
        end
        else if (take)
        begin
            if (stream.last_byte)
            begin
                position_reg  <= '0;
                magic_reg     <= 1'b1;
                version_reg   <= '0;
                size_reg      <= '0;
                check_reg     <= '0;
                flag_reg      <= 1'b0;
                body_crc_reg  <= svc_pkg::CRC_PRESET;
                whole_crc_reg <= svc_pkg::CRC_PRESET;
                ovf_reg       <= 1'b0;
            end
            else
            begin
                position_reg  <= position_next;
                magic_reg     <= magic_next;
                version_reg   <= version_next;
                size_reg      <= size_next;
                check_reg     <= check_next;
                flag_reg      <= flag_next;
                body_crc_reg  <= body_crc_next;
                whole_crc_reg <= whole_crc_next;
                ovf_reg       <= ovf_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take && stream.last_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (verdict.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && stream.last_byte)
        begin
            out_accepted_reg <= ok;
            out_count_reg    <= position_next;
            out_crc_reg      <= whole_crc_next ^ svc_pkg::CRC_PRESET;
        end
    end

    assign verdict.valid      = out_valid_reg;
    assign verdict.accepted   = out_accepted_reg;
    assign verdict.stream_len = out_count_reg;
    assign verdict.stream_crc = out_crc_reg;

    a_last_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (take && stream.last_byte) |=> verdict.valid)
        else $error("last byte taken without a verdict");

    a_last_clears_stream: assert property (@(posedge clk) disable iff (!rst_n)
        (take && stream.last_byte) |=> (position_reg == '0 && magic_reg && !ovf_reg))
        else $error("stream state not cleared after last byte");

    a_accept_needs_header: assert property (@(posedge clk) disable iff (!rst_n)
        (verdict.valid && verdict.accepted) |->
        (verdict.stream_len >= svc_pkg::BODY_OFS))
        else $error("accepted stream shorter than header");

endmodule
